// ----- rtl/noisy_range_bearing_observer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the noisy range/bearing observer
// Reset-qualified implication checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef NOISY_RANGE_BEARING_OBSERVER_ASSERT_SVH
`define NOISY_RANGE_BEARING_OBSERVER_ASSERT_SVH

// same-cycle implication
`define NRBO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nrbo: same-cycle check failed");

// next-cycle implication
`define NRBO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nrbo: next-cycle check failed");

`endif

// ----- rtl/nrbo_pkg.sv -----
// ---------------------------------------------------------------------------
// nrbo_pkg
// Types, constants and the arctangent table of the range/bearing observer.
// ---------------------------------------------------------------------------
package nrbo_pkg;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_MX, S_MY, S_SUM, S_RSQ, S_RCHK, S_VPRE, S_VEC,
		S_BEAR, S_WRAP, S_FOV,
		G_L1, G_L1W, G_L2, G_L2W, G_NORM, G_SQ, G_SQW, G_NL, G_R, G_SQRT,
		G_ANG, G_ANGW, G_ROT, G_CS, G_G, G_N,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		REG_RANGE_LIMIT   = 2'd0,
		REG_FOV_HALF      = 2'd1,
		REG_RANGE_SIGMA   = 2'd2,
		REG_BEARING_SIGMA = 2'd3
	} reg_idx_t;

	localparam logic [30:0] RANGE_LIMIT_RST   = 31'd1310720;
	localparam logic [17:0] FOV_HALF_RST      = 18'd102944;
	localparam logic [23:0] RANGE_SIGMA_RST   = 24'd6554;
	localparam logic [15:0] BEARING_SIGMA_RST = 16'd655;

	localparam logic [31:0] SEED_INIT = 32'h9e3779b9;
	localparam logic [31:0] LCG_MUL   = 32'd1664525;
	localparam logic [31:0] LCG_ADD   = 32'd1013904223;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;
	localparam logic [30:0]        LN2_X2_Q30  = 31'd1488522236;

	localparam logic [4:0] CORDIC_LAST = 5'd23;
	localparam logic [4:0] SQRT_FIRST  = 5'd31;
	localparam logic [4:0] NORM_K_INIT = 5'd23;
	localparam logic [4:0] LOG_FIRST   = 5'd23;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] v;
		case (i)
			5'd0:  v = 36'sd843314856;
			5'd1:  v = 36'sd497837829;
			5'd2:  v = 36'sd263043836;
			5'd3:  v = 36'sd133525158;
			5'd4:  v = 36'sd67021686;
			5'd5:  v = 36'sd33543515;
			5'd6:  v = 36'sd16775850;
			5'd7:  v = 36'sd8388437;
			5'd8:  v = 36'sd4194282;
			5'd9:  v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			default: v = 36'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/noisy_range_bearing_observer.sv -----
// ---------------------------------------------------------------------------
// noisy_range_bearing_observer
// Landmark range/bearing sensor with Box-Muller Gaussian noise.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per transaction: a
//   landmark test (req_type 0) or a reseed of the noise generator (req_type 1).
//   Output channel (out_valid/out_ready) delivers zero or one observation per
//   landmark test. The user writes registers through cfg_we/cfg_index/cfg_data
//   only while the block is idle; the block itself does not enforce this.
//   One sequencer drives a shared 33x35 multiplier, a shared bit-serial square
//   root (32 steps) and a shared CORDIC stage (24 steps). A reseed is done in
//   the idle state. A rejected landmark returns the block to idle. An accepted
//   one draws two noise samples before its result loads, each computed through
//   the 24 squarings of the log, the square root and the cosine CORDIC.
//   in_ready is high only while the sequencer is idle; one request at a time.
//   A finished observation sits in the output register; if the receiver
//   stalls, the next observation waits in its last state until the register
//   frees, and only then does the input side accept the following request.
//   Reset clears the registers to their defaults, reseeds the generator and
//   clears the observation count.
// ---------------------------------------------------------------------------
module noisy_range_bearing_observer #(
	parameter int MAX_OBS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic               start_scan,
	input  logic signed [31:0] cone_x,
	input  logic signed [31:0] cone_y,
	input  logic               cone_color,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [19:0] pose_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] obs_range,
	output logic signed [19:0] obs_bearing,
	output logic               obs_color,
	output logic [5:0]         obs_index,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import nrbo_pkg::*;

	localparam int CNT_W = $clog2(MAX_OBS + 1);

	state_t state_q, state_d;

	logic [30:0] rlim_q;
	logic [17:0] fov_q;
	logic [23:0] rsig_q;
	logic [15:0] bsig_q;
	logic [31:0] seed_q;
	logic [CNT_W-1:0] cnt_q;
	logic ov_q;

	logic signed [32:0] dx_q, dy_q;
	logic signed [19:0] head_q;
	logic color_q;
	logic [32:0] adx, ady;

	logic signed [32:0] mul_a;
	logic signed [34:0] mul_b;
	logic signed [67:0] prod_q;
	logic [62:0] acc_q;

	logic [63:0] rt_n_q, rt_res_q, sq_bit, sq_trial;
	logic sq_ge;
	logic [4:0] it_q;

	logic signed [35:0] cx_q, cy_q, cz_q, cx_sh, cy_sh;
	logic cr_pos;
	logic signed [35:0] dxe, dye;

	logic [31:0] range_q;
	logic signed [35:0] b_q, brnd;
	logic signed [21:0] bq, bq_abs, bq_q;

	logic gsel_q;
	logic [31:0] seed_nxt;
	logic [23:0] u1_q, u2_q;
	logic [4:0] k_q;
	logic [30:0] mant_q;
	logic [23:0] frac_q;
	logic [31:0] sq_t;
	logic [28:0] nl;
	logic [26:0] sq_q;
	logic signed [34:0] cs;
	logic signed [67:0] nrnd;
	logic signed [28:0] rn_q;
	logic signed [20:0] bn_q;

	logic signed [33:0] rsum;
	logic signed [22:0] bsum;
	logic signed [31:0] rsat;
	logic signed [19:0] bsat;
	logic out_free;

	// ---------------- combinational helpers ----------------
	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign dxe = {{3{dx_q[32]}}, dx_q};
	assign dye = {{3{dy_q[32]}}, dy_q};

	// square root step
	assign sq_bit   = 64'd1 << {it_q, 1'b0};
	assign sq_trial = rt_res_q + sq_bit;
	assign sq_ge    = rt_n_q >= sq_trial;

	// CORDIC step, vectoring in S_VEC, rotation otherwise
	assign cx_sh  = cx_q >>> it_q;
	assign cy_sh  = cy_q >>> it_q;
	assign cr_pos = (state_q == S_VEC) ? !(cy_q > 36'sd0) : !cz_q[35];

	assign brnd   = b_q + 36'sd8192;
	assign bq     = brnd[35:14];
	assign bq_abs = bq[21] ? -bq : bq;

	assign seed_nxt = prod_q[31:0] + LCG_ADD;
	assign sq_t     = prod_q[61:30];
	assign nl       = {NORM_K_INIT + 5'd1, 24'd0} - {k_q, frac_q};
	assign nrnd     = prod_q + 68'sd8388608;

	always_comb begin
		case (u2_q[23:22])
			2'd0: cs = cx_q[34:0];
			2'd1: cs = -cy_q[34:0];
			2'd2: cs = -cx_q[34:0];
			default: cs = cy_q[34:0];
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MX: begin
				mul_a = {1'b0, adx[31:0]};
				mul_b = {3'b0, adx[31:0]};
			end
			S_MY: begin
				mul_a = {1'b0, ady[31:0]};
				mul_b = {3'b0, ady[31:0]};
			end
			G_L1, G_L2: begin
				mul_a = {1'b0, seed_q};
				mul_b = {3'b0, LCG_MUL};
			end
			G_SQ: begin
				mul_a = {2'b0, mant_q};
				mul_b = {4'b0, mant_q};
			end
			G_NL: begin
				mul_a = {4'b0, nl};
				mul_b = {4'b0, LN2_X2_Q30};
			end
			G_ANG: begin
				mul_a = {11'b0, u2_q[21:0]};
				mul_b = HALF_PI_Q30[34:0];
			end
			G_CS: begin
				mul_a = {6'b0, sq_q};
				mul_b = cs;
			end
			G_G: begin
				mul_a = prod_q[62:30];
				mul_b = gsel_q ? {19'b0, bsig_q} : {11'b0, rsig_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// output saturation
	assign rsum = {2'b0, range_q} + {{5{rn_q[28]}}, rn_q};
	assign bsum = {bq_q[21], bq_q} + {{2{bn_q[20]}}, bn_q};
	assign rsat = (rsum[33:31] == 3'b000 || rsum[33:31] == 3'b111) ? rsum[31:0]
		: (rsum[33] ? 32'sh80000000 : 32'sh7fffffff);
	assign bsat = (bsum[22:19] == 4'b0000 || bsum[22:19] == 4'b1111) ? bsum[19:0]
		: (bsum[22] ? 20'sh80000 : 20'sh7ffff);

	assign out_free = !ov_q || out_ready;

	// ---------------- next state ----------------
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: if (in_valid && !req_type) state_d = S_CHK;
			S_CHK: begin
				if (adx > {2'b0, rlim_q} || ady > {2'b0, rlim_q}) state_d = S_IDLE;
				else state_d = S_MX;
			end
			S_MX:  state_d = S_MY;
			S_MY:  state_d = S_SUM;
			S_SUM: state_d = S_RSQ;
			S_RSQ: if (it_q == 5'd0) state_d = S_RCHK;
			S_RCHK: begin
				if (rt_res_q > {33'b0, rlim_q}) state_d = S_IDLE;
				else state_d = S_VPRE;
			end
			S_VPRE: state_d = (dx_q == 33'sd0 && dy_q == 33'sd0) ? S_BEAR : S_VEC;
			S_VEC:  if (it_q == CORDIC_LAST) state_d = S_BEAR;
			S_BEAR: state_d = S_WRAP;
			S_WRAP: if (!(b_q > PI_Q30) && !(b_q < -PI_Q30)) state_d = S_FOV;
			S_FOV: begin
				if (bq_abs > {4'b0, fov_q} || cnt_q >= CNT_W'(MAX_OBS)) state_d = S_IDLE;
				else state_d = G_L1;
			end
			G_L1:   state_d = G_L1W;
			G_L1W:  state_d = G_L2;
			G_L2:   state_d = G_L2W;
			G_L2W:  state_d = G_NORM;
			G_NORM: if (u1_q[23]) state_d = G_SQ;
			G_SQ:   state_d = G_SQW;
			G_SQW:  state_d = (it_q == 5'd0) ? G_NL : G_SQ;
			G_NL:   state_d = G_R;
			G_R:    state_d = G_SQRT;
			G_SQRT: if (it_q == 5'd0) state_d = G_ANG;
			G_ANG:  state_d = G_ANGW;
			G_ANGW: state_d = G_ROT;
			G_ROT:  if (it_q == CORDIC_LAST) state_d = G_CS;
			G_CS:   state_d = G_G;
			G_G:    state_d = G_N;
			G_N:    state_d = gsel_q ? S_OUT : G_L1;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rlim_q  <= RANGE_LIMIT_RST;
			fov_q   <= FOV_HALF_RST;
			rsig_q  <= RANGE_SIGMA_RST;
			bsig_q  <= BEARING_SIGMA_RST;
			seed_q  <= SEED_INIT;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_LIMIT:   rlim_q <= cfg_data;
					REG_FOV_HALF:      fov_q  <= cfg_data[17:0];
					REG_RANGE_SIGMA:   rsig_q <= cfg_data[23:0];
					REG_BEARING_SIGMA: bsig_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == S_IDLE && in_valid) begin
				if (req_type) seed_q <= SEED_INIT;
				else if (start_scan) cnt_q <= '0;
			end
			if (state_q == G_L1W || state_q == G_L2W) seed_q <= seed_nxt;
			if (state_q == S_OUT && out_free) begin
				ov_q  <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				dx_q    <= {cone_x[31], cone_x} - {pose_x[31], pose_x};
				dy_q    <= {cone_y[31], cone_y} - {pose_y[31], pose_y};
				head_q  <= pose_heading;
				color_q <= cone_color;
			end
			S_MY: acc_q <= prod_q[62:0];
			S_SUM: begin
				rt_n_q   <= {1'b0, acc_q} + {1'b0, prod_q[62:0]};
				rt_res_q <= '0;
				it_q     <= SQRT_FIRST;
			end
			S_RSQ, G_SQRT: begin
				if (sq_ge) begin
					rt_n_q   <= rt_n_q - sq_trial;
					rt_res_q <= (rt_res_q >> 1) + sq_bit;
				end else begin
					rt_res_q <= rt_res_q >> 1;
				end
				it_q <= it_q - 5'd1;
			end
			S_RCHK: range_q <= rt_res_q[31:0];
			S_VPRE: begin
				it_q <= '0;
				if (dx_q == 33'sd0 && dy_q == 33'sd0) begin
					cz_q <= '0;
				end else if (dx_q[32] && !dy_q[32]) begin
					cx_q <= dye;
					cy_q <= -dxe;
					cz_q <= HALF_PI_Q30;
				end else if (dx_q[32]) begin
					cx_q <= -dye;
					cy_q <= dxe;
					cz_q <= -HALF_PI_Q30;
				end else begin
					cx_q <= dxe;
					cy_q <= dye;
					cz_q <= '0;
				end
			end
			S_VEC, G_ROT: begin
				if (cr_pos) begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					cz_q <= cz_q - atan_q30(it_q);
				end else begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					cz_q <= cz_q + atan_q30(it_q);
				end
				it_q <= it_q + 5'd1;
			end
			S_BEAR: b_q <= cz_q - {{2{head_q[19]}}, head_q, 14'b0};
			S_WRAP: begin
				// bring the bearing back into plus or minus pi
				if (b_q > PI_Q30) b_q <= b_q - TWO_PI_Q30;
				else if (b_q < -PI_Q30) b_q <= b_q + TWO_PI_Q30;
			end
			S_FOV: begin
				bq_q   <= bq;
				gsel_q <= 1'b0;
			end
			G_L1W: u1_q <= (seed_nxt[31:8] == 24'd0) ? 24'd1 : seed_nxt[31:8];
			G_L2W: begin
				u2_q <= seed_nxt[31:8];
				k_q  <= NORM_K_INIT;
			end
			G_NORM: begin
				// shift the leading one up to the top bit
				if (!u1_q[23]) begin
					u1_q <= {u1_q[22:0], 1'b0};
					k_q  <= k_q - 5'd1;
				end else begin
					mant_q <= {u1_q, 7'b0};
					frac_q <= '0;
					it_q   <= LOG_FIRST;
				end
			end
			G_SQW: begin
				if (sq_t[31]) begin
					mant_q <= sq_t[31:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					mant_q <= sq_t[30:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
				it_q <= it_q - 5'd1;
			end
			G_R: begin
				rt_n_q   <= {10'b0, prod_q[59:30], 24'b0};
				rt_res_q <= '0;
				it_q     <= SQRT_FIRST;
			end
			G_ANG: sq_q <= rt_res_q[26:0];
			G_ANGW: begin
				cx_q <= CORDIC_K;
				cy_q <= '0;
				cz_q <= {5'b0, prod_q[52:22]};
				it_q <= '0;
			end
			G_N: begin
				if (gsel_q) bn_q <= nrnd[44:24];
				else rn_q <= nrnd[52:24];
				gsel_q <= 1'b1;
			end
			S_OUT: begin
				if (out_free) begin
					obs_range   <= rsat;
					obs_bearing <= bsat;
					obs_color   <= color_q;
					obs_index   <= 6'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;

	// ---------------- assertions ----------------
	`include "noisy_range_bearing_observer_assert.svh"

	`NRBO_ASSERT_NEXT(a_reseed, clk, arst_n, in_valid && in_ready && req_type, seed_q == SEED_INIT)
	`NRBO_ASSERT_NOW(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_OBS))
	`NRBO_ASSERT_NEXT(a_out_load, clk, arst_n, state_q == S_OUT && out_free, out_valid && cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ----- verif/nrbo_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nrbo_checker
// Watches the request, observation and register-write ports of the observer,
// predicts each observation from the landmark geometry and the noise
// generator, and compares every delivered observation field by field.
// ---------------------------------------------------------------------------
module nrbo_checker #(
	parameter int MAX_OBS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               req_type,
	input  logic               start_scan,
	input  logic signed [31:0] cone_x,
	input  logic signed [31:0] cone_y,
	input  logic               cone_color,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [19:0] pose_heading,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] obs_range,
	input  logic signed [19:0] obs_bearing,
	input  logic               obs_color,
	input  logic [5:0]         obs_index,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);
	import nrbo_pkg::*;

	typedef struct {
		logic signed [31:0] rng;
		logic signed [19:0] brg;
		logic               color;
		logic [5:0]         idx;
	} observation_t;

	observation_t expected_obs[$];

	logic [30:0] lim_q;
	logic [17:0] fov_q;
	logic [23:0] rsig_q;
	logic [15:0] bsig_q;
	logic [31:0] seed_q;
	logic [6:0]  count_q;

	assign pending = expected_obs.size();

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bit_q;
		res = 0;
		bit_q = 64'd1 << 62;
		while (bit_q > n) bit_q >>= 2;
		while (bit_q != 0) begin
			if (n >= res + bit_q) begin
				n -= res + bit_q;
				res = (res >> 1) + bit_q;
			end else begin
				res >>= 1;
			end
			bit_q >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(input longint x, input longint y);
		longint z, t, nx, ny;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Q30;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Q30;
			end
		end
		for (int i = 0; i < 24; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q30(5'(i));
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q30(5'(i));
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	function automatic logic [23:0] next_uniform();
		seed_q = seed_q * LCG_MUL + LCG_ADD;
		return seed_q[31:8];
	endfunction

	// one standard normal sample in Q24
	function automatic longint normal_q24();
		logic [23:0] u1, u2;
		longint unsigned mant, nl, r, sq, frac;
		longint ang, x, y, z, nx, ny, cs;
		int k;
		u1 = next_uniform();
		u2 = next_uniform();
		if (u1 == 0) u1 = 1;
		k = 23;
		while (!u1[k]) k--;
		mant = longint'(u1) << (30 - k);
		frac = 0;
		for (int i = 1; i <= 24; i++) begin
			mant = (mant * mant) >> 30;
			if (mant >= (64'd1 << 31)) begin
				mant >>= 1;
				frac |= 64'd1 << (24 - i);
			end
		end
		nl = (64'd24 << 24) - ((longint'(k) << 24) + frac);
		r = (nl * longint'(LN2_X2_Q30)) >> 30;
		sq = int_sqrt(r << 24);
		ang = longint'((longint'(u2[21:0]) * longint'(HALF_PI_Q30)) >> 22);
		x = CORDIC_K; y = 0; z = ang;
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q30(5'(i));
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q30(5'(i));
			end
			x = nx; y = ny;
		end
		case (u2[23:22])
			2'd0: cs = x;
			2'd1: cs = -y;
			2'd2: cs = -x;
			default: cs = y;
		endcase
		return (longint'(sq) * cs) >>> 30;
	endfunction

	// return 1 and fill o when the landmark yields an observation
	function automatic bit observe(output observation_t o);
		longint dx, dy, adx, ady, b, bq, g, rn, bn, rs;
		longint unsigned rng;
		dx = longint'(cone_x) - longint'(pose_x);
		dy = longint'(cone_y) - longint'(pose_y);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx > longint'(lim_q) || ady > longint'(lim_q)) return 0;
		rng = int_sqrt(longint'(adx * adx) + longint'(ady * ady));
		if (rng > longint'(lim_q)) return 0;
		b = vector_angle(dx, dy) - longint'(pose_heading) * 16384;
		while (b > PI_Q30) b -= TWO_PI_Q30;
		while (b < -PI_Q30) b += TWO_PI_Q30;
		bq = (b + 8192) >>> 14;
		if ((bq < 0 ? -bq : bq) > longint'(fov_q)) return 0;
		if (count_q >= MAX_OBS) return 0;
		g = normal_q24();
		rn = (longint'(rsig_q) * g + (64'sd1 <<< 23)) >>> 24;
		g = normal_q24();
		bn = (longint'(bsig_q) * g + (64'sd1 <<< 23)) >>> 24;
		rs = longint'(rng) + rn;
		if (rs > 64'sd2147483647) rs = 64'sd2147483647;
		if (rs < -64'sd2147483648) rs = -64'sd2147483648;
		bq = bq + bn;
		if (bq > 524287) bq = 524287;
		if (bq < -524288) bq = -524288;
		o.rng = rs[31:0];
		o.brg = bq[19:0];
		o.color = cone_color;
		o.idx = count_q[5:0];
		count_q = count_q + 7'd1;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		observation_t o, e;
		if (!arst_n) begin
			lim_q <= RANGE_LIMIT_RST;
			fov_q <= FOV_HALF_RST;
			rsig_q <= RANGE_SIGMA_RST;
			bsig_q <= BEARING_SIGMA_RST;
			seed_q = SEED_INIT;
			count_q = '0;
			fail_count <= 0;
			expected_obs.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_RANGE_LIMIT:   lim_q <= cfg_data;
					REG_FOV_HALF:      fov_q <= cfg_data[17:0];
					REG_RANGE_SIGMA:   rsig_q <= cfg_data[23:0];
					REG_BEARING_SIGMA: bsig_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (req_type) begin
					seed_q = SEED_INIT;
				end else begin
					if (start_scan) count_q = '0;
					if (observe(o)) expected_obs.push_back(o);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_obs.size() == 0) begin
					$error("unexpected observation: range %0d bearing %0d", obs_range,
						obs_bearing);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_obs.pop_front();
					if (obs_range !== e.rng || obs_bearing !== e.brg
							|| obs_color !== e.color || obs_index !== e.idx) begin
						fail_count <= fail_count + 1;
						if (obs_range !== e.rng)
							$error("obs_range: expected %0d, got %0d", e.rng, obs_range);
						if (obs_bearing !== e.brg)
							$error("obs_bearing: expected %0d, got %0d", e.brg, obs_bearing);
						if (obs_color !== e.color)
							$error("obs_color: expected %0d, got %0d", e.color, obs_color);
						if (obs_index !== e.idx)
							$error("obs_index: expected %0d, got %0d", e.idx, obs_index);
					end
				end
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives landmark and reseed requests through the observer under several
// register settings with random gaps and output stalls; the checker beside
// the block predicts and compares every observation.
// ---------------------------------------------------------------------------
module tb;
	import nrbo_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic               start_scan;
	logic signed [31:0] cone_x;
	logic signed [31:0] cone_y;
	logic               cone_color;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [19:0] pose_heading;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] obs_range;
	logic signed [19:0] obs_bearing;
	logic               obs_color;
	logic [5:0]         obs_index;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [30:0]        cfg_data;
	int                 fail_count;
	int                 pending;
	bit                 idling_on;
	bit                 first_sent;

	noisy_range_bearing_observer DUT (.*);
	nrbo_checker chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// random value in [-span, span]
	function automatic int offset(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send(input bit rt, input bit ss, input int cx, input int cy, input bit col,
			input int px, input int py, input int hd);
		int gap;
		gap = idling_on ? $urandom_range(0, 12) : 0;
		if (first_sent) begin
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_sent = 1;
		req_type <= rt;
		start_scan <= ss;
		cone_x <= cx;
		cone_y <= cy;
		cone_color <= col;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= 20'(hd);
		in_valid <= 1'b1;
	endtask

	task automatic drain();
		if (first_sent) begin
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			in_valid <= 1'b0;
			first_sent = 0;
		end
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_regs(input logic [30:0] lim, input logic [30:0] fov,
			input logic [30:0] rs, input logic [30:0] bs);
		reg_idx_t idx[4];
		logic [30:0] val[4];
		idx = '{REG_RANGE_LIMIT, REG_FOV_HALF, REG_RANGE_SIGMA, REG_BEARING_SIGMA};
		val = '{lim, fov, rs, bs};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// scans around a random pose; span sets how far landmarks scatter
	task automatic run_scans(input int n_items, input int span);
		int px, py, n, len;
		n = 0;
		while (n < n_items) begin
			px = ($urandom_range(0, 7) == 0) ? int'($urandom) : offset(1 << 24);
			py = ($urandom_range(0, 7) == 0) ? int'($urandom) : offset(1 << 24);
			len = ($urandom_range(0, 9) == 0) ? 75 : $urandom_range(1, 20);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 19))
					0: send(1'b1, 1'($urandom), $urandom, $urandom, 1'($urandom), $urandom,
						$urandom, $urandom);
					1: send(1'b0, 1'($urandom), $urandom, $urandom, 1'($urandom), $urandom,
						$urandom, $urandom);
					2: send(1'b0, i == 0, px, py, 1'($urandom), px, py, offset(2000));
					default: send(1'b0, i == 0, px + offset(span), py + offset(span),
						1'($urandom), px, py, ($urandom_range(0, 3) == 0) ?
						offset(524288) : offset(110000));
				endcase
				n++;
			end
		end
	endtask

	// receiver side: random stall before each transaction
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			n = idling_on ? $urandom_range(0, 12) : 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		start_scan = 1'b0;
		cone_x = '0;
		cone_y = '0;
		cone_color = 1'b0;
		pose_x = '0;
		pose_y = '0;
		pose_heading = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idling_on = 1;
		first_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: geometry corners under reset settings
		send(1'b0, 1'b1, 5 << 16, 0, 1'b0, 0, 0, 0);
		send(1'b0, 1'b0, 0, 5 << 16, 1'b1, 0, 0, 102944);
		send(1'b0, 1'b0, -(5 << 16), 0, 1'b0, 0, 0, 0);
		send(1'b0, 1'b0, 30 << 16, 0, 1'b1, 0, 0, 0);
		send(1'b0, 1'b0, 0, 0, 1'b0, 0, 0, 0);
		send(1'b0, 1'b0, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 32'sh80000000,
			32'sh80000000, 0);
		send(1'b0, 1'b0, 32'sh80000000, 0, 1'b0, 32'sh7fffffff, 0, 0);
		send(1'b0, 1'b0, -(3 << 16), 1, 1'b1, 0, 0, 205887);
		send(1'b0, 1'b0, -(3 << 16), -1, 1'b0, 0, 0, -205887);
		send(1'b0, 1'b0, 4 << 16, 4 << 16, 1'b1, 0, 0, 524287);
		send(1'b0, 1'b0, 4 << 16, -(4 << 16), 1'b0, 0, 0, -524288);
		send(1'b1, 1'b1, 32'sh7fffffff, 0, 1'b1, 0, 0, 0);
		send(1'b0, 1'b0, 1 << 16, 0, 1'b1, 0, 0, 0);
		send(1'b0, 1'b1, 20 << 16, 0, 1'b0, 0, 0, 0);
		send(1'b0, 1'b0, (20 << 16) + 1, 0, 1'b0, 0, 0, 0);
		run_scans(280, 30 << 16);
		drain();

		// widest settings and largest noise, first without idling, then with it
		idling_on = 0;
		write_regs(31'h7fffffff, 31'd205887, 31'hffffff, 31'hffff);
		run_scans(150, 1 << 30);
		idling_on = 1;
		run_scans(150, 1 << 20);
		drain();

		// everything zero: only a landmark on the pose dead ahead passes
		write_regs(31'd0, 31'd0, 31'd0, 31'd0);
		send(1'b0, 1'b1, 0, 0, 1'b1, 0, 0, 0);
		send(1'b0, 1'b0, 1, 0, 1'b0, 0, 0, 0);
		run_scans(150, 2);
		drain();

		write_regs(31'($urandom_range(1 << 16, 100 << 16)), 31'($urandom_range(0, 205887)),
			31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 65535)));
		run_scans(300, 60 << 16);
		drain();

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
